// ----- hdl/sorted_priority_queue_unit_assert.svh -----
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/spq_pkg.sv -----
package spq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int PRIO_BITS_DEF = 16;
  localparam int VALUE_BITS    = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_in;   // accepted insert: open a slot, shift tail right
    logic shift_out;  // accepted remove: each cell but the tail takes its right neighbor
  } cell_cmd_t;

endpackage

// ----- hdl/spq_cell.sv -----
module spq_cell import spq_pkg::*; #(
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                         clk,
  input  cell_cmd_t                    cmd,
  input  logic                         occupied,
  input  logic signed [VALUE_BITS-1:0] new_value,
  input  logic        [PRIO_BITS-1:0]  new_prio,
  input  logic signed [VALUE_BITS-1:0] left_value,
  input  logic        [PRIO_BITS-1:0]  left_prio,
  input  logic                         left_after,
  input  logic signed [VALUE_BITS-1:0] right_value,
  input  logic        [PRIO_BITS-1:0]  right_prio,
  output logic                         after,
  output logic signed [VALUE_BITS-1:0] value,
  output logic        [PRIO_BITS-1:0]  prio
);

  logic signed [VALUE_BITS-1:0] value_next;
  logic        [PRIO_BITS-1:0]  prio_next;

  // At or past the insert point: empty, or strictly larger priority.
  assign after = !occupied || (prio > new_prio);

  always_comb begin
    value_next = value;
    prio_next  = prio;
    priority if (cmd.shift_in && after) begin
      if (left_after) begin
        value_next = left_value;
        prio_next  = left_prio;
      end else begin
        value_next = new_value;
        prio_next  = new_prio;
      end
    end else if (cmd.shift_out) begin
      value_next = right_value;
      prio_next  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    prio  <= prio_next;
  end

endmodule

// ----- hdl/sorted_priority_queue_unit.sv -----
// Sorted priority queue built as a chain of compare-and-shift cells.
// The result of an accepted input transaction is registered.
// Throughput: 1 transaction per cycle; all cells compare in parallel and
// the output register frees the input unless the result is stalled.
// Reset (rst, synchronous): entry count and output valid cleared; cell
// contents and result fields hold until written and are not used before.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic signed [VALUE_BITS-1:0] item_value,
  input  logic        [PRIO_BITS-1:0]  item_priority,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [1:0]            status,
  output logic signed [VALUE_BITS-1:0] head_value,
  output logic        [PRIO_BITS-1:0]  head_priority,
  output logic        [CNT_W-1:0]      fill_count
);

  // Cell chain: cell 0 is the head (lowest priority value).
  logic signed [VALUE_BITS-1:0] cell_value [DEPTH];
  logic        [PRIO_BITS-1:0]  cell_prio  [DEPTH];
  logic                         cell_after [DEPTH];

  cell_cmd_t cmd;

  // Stored entry count.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Result register contents.
  status_t                      status_q;
  status_t                      status_next;
  logic signed [VALUE_BITS-1:0] head_value_next;
  logic        [PRIO_BITS-1:0]  head_priority_next;

  logic accept;
  logic full;
  logic empty;

  // Input is held only while a finished result waits downstream.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [VALUE_BITS-1:0] lv;
    logic        [PRIO_BITS-1:0]  lp;
    logic                         la;
    logic signed [VALUE_BITS-1:0] rv;
    logic        [PRIO_BITS-1:0]  rp;

    if (k == 0) begin : g_head
      // Nothing left of the head: it can only take the new entry.
      assign lv = item_value;
      assign lp = item_priority;
      assign la = 1'b0;
    end else begin : g_body
      assign lv = cell_value[k-1];
      assign lp = cell_prio[k-1];
      assign la = cell_after[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      // Tail keeps its own data on a remove; it is then beyond the count.
      assign rv = cell_value[k];
      assign rp = cell_prio[k];
    end else begin : g_inner
      assign rv = cell_value[k+1];
      assign rp = cell_prio[k+1];
    end

    spq_cell #(
      .PRIO_BITS(PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (CNT_W'(k) < count),
      .new_value  (item_value),
      .new_prio   (item_priority),
      .left_value (lv),
      .left_prio  (lp),
      .left_after (la),
      .right_value(rv),
      .right_prio (rp),
      .after      (cell_after[k]),
      .value      (cell_value[k]),
      .prio       (cell_prio[k])
    );
  end

  // Decode the accepted transaction; refused ones leave the chain alone.
  always_comb begin
    cmd                = '0;
    count_next         = count;
    status_next        = ST_DONE;
    head_value_next    = '0;
    head_priority_next = '0;
    if (accept) begin
      unique case (opcode_t'(opcode))
        OP_INSERT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            cmd.shift_in = 1'b1;
            count_next   = count + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            cmd.shift_out      = 1'b1;
            count_next         = count - 1'b1;
            head_value_next    = cell_value[0];
            head_priority_next = cell_prio[0];
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload loads only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q      <= status_next;
      head_value    <= head_value_next;
      head_priority <= head_priority_next;
      fill_count    <= count_next;
    end
  end

  assign status = status_q;

endmodule

// ----- hdl/spq_checker.sv -----
`include "sorted_priority_queue_unit_assert.svh"

module spq_checker import spq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic        [1:0]            status,
  input logic signed [VALUE_BITS-1:0] head_value,
  input logic        [PRIO_BITS-1:0]  head_priority,
  input logic        [CNT_W-1:0]      fill_count
);

  `SPQ_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "out_valid after reset")

  `SPQ_ASSERT(a_stall_holds,
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(head_value)
      && $stable(fill_count),
    "stalled result changed")

  `SPQ_ASSERT(a_full_count,
    out_valid && (status == ST_FULL) |-> fill_count == CNT_W'(DEPTH)
      && head_value == '0 && head_priority == '0,
    "full result inconsistent")

  `SPQ_ASSERT(a_empty_count,
    out_valid && (status == ST_EMPTY) |-> fill_count == '0
      && head_value == '0 && head_priority == '0,
    "empty result inconsistent")

  `SPQ_ASSERT(a_count_range, out_valid |-> fill_count <= CNT_W'(DEPTH), "fill count above depth")

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .DEPTH    (DEPTH),
  .PRIO_BITS(PRIO_BITS),
  .CNT_W    (CNT_W)
) u_spq_checker (.*);

// ----- tb/sorted_priority_queue_unit_tb.sv -----
module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int PRIO_W      = PRIO_BITS_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int RANDOM_TXNS = 950;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOW_MAX    = 10;

  // One result as seen on the output ports.
  typedef struct packed {
    status_t                 status;
    logic [VALUE_BITS-1:0]   value;
    logic [PRIO_W-1:0]       prio;
    logic [CNT_W-1:0]        count;
  } pq_result_t;

  // Directed stimulus row; chk selects a typed-in expectation over the prediction.
  typedef struct packed {
    opcode_t                 op;
    logic [VALUE_BITS-1:0]   value;
    logic [PRIO_W-1:0]       prio;
    logic                    chk;
    pq_result_t              res;
  } dir_row_t;

  localparam int DIR_ROWS_N = 25;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // remove on an empty queue straight after reset
    '{OP_REMOVE, 32'h0000_0000, 16'h0000, 1'b1, '{ST_EMPTY, 32'h0, 16'h0, 5'd0}},
    // extremes in, lowest priority value must come out first
    '{OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, '{ST_DONE, 32'h0, 16'h0, 5'd1}},
    '{OP_INSERT, 32'h8000_0000, 16'h0000, 1'b1, '{ST_DONE, 32'h0, 16'h0, 5'd2}},
    '{OP_REMOVE, 32'h0000_0000, 16'h0000, 1'b1,
      '{ST_DONE, 32'h8000_0000, 16'h0000, 5'd1}},
    '{OP_REMOVE, 32'h0000_0000, 16'h0000, 1'b1,
      '{ST_DONE, 32'h7FFF_FFFF, 16'hFFFF, 5'd0}},
    '{OP_REMOVE, 32'h1234_5678, 16'h5555, 1'b1, '{ST_EMPTY, 32'h0, 16'h0, 5'd0}},
    // fill to DEPTH with ties, extremes and mid-range priorities
    '{OP_INSERT, 32'h1111_1111, 16'h0008, 1'b0, '0},
    '{OP_INSERT, 32'h2222_2222, 16'h0008, 1'b0, '0},
    '{OP_INSERT, 32'h3333_3333, 16'h0003, 1'b0, '0},
    '{OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0000, 16'h0008, 1'b0, '0},
    '{OP_INSERT, 32'hA5A5_A5A5, 16'h0000, 1'b0, '0},
    '{OP_INSERT, 32'h5A5A_5A5A, 16'h0003, 1'b0, '0},
    '{OP_INSERT, 32'h4444_4444, 16'h0008, 1'b0, '0},
    '{OP_INSERT, 32'h8000_0001, 16'hFFFF, 1'b0, '0},
    '{OP_INSERT, 32'h7FFF_FFFE, 16'h0000, 1'b0, '0},
    '{OP_INSERT, 32'h5555_5555, 16'h0001, 1'b0, '0},
    '{OP_INSERT, 32'hAAAA_AAAA, 16'h0008, 1'b0, '0},
    '{OP_INSERT, 32'h6666_6666, 16'h7FFF, 1'b0, '0},
    '{OP_INSERT, 32'h9999_9999, 16'h8000, 1'b0, '0},
    '{OP_INSERT, 32'hCCCC_CCCC, 16'h0003, 1'b0, '0},
    '{OP_INSERT, 32'h0F0F_F0F0, 16'h0008, 1'b0, '0},
    // queue full: insert refused, nothing changes
    '{OP_INSERT, 32'hDEAD_BEEF, 16'h0000, 1'b1, '{ST_FULL, 32'h0, 16'h0, 5'd16}},
    // remove with junk on the ignored payload fields
    '{OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
    '{OP_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, '0}
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         opcode = 1'b0;
  logic signed [VALUE_BITS-1:0] item_value = '0;
  logic        [PRIO_W-1:0]     item_priority = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic        [1:0]            status;
  logic signed [VALUE_BITS-1:0] head_value;
  logic        [PRIO_W-1:0]     head_priority;
  logic        [CNT_W-1:0]      fill_count;

  sorted_priority_queue_unit #(
    .DEPTH    (DEPTH),
    .PRIO_BITS(PRIO_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .item_value   (item_value),
    .item_priority(item_priority),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .head_value   (head_value),
    .head_priority(head_priority),
    .fill_count   (fill_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the queue contents, kept sorted like the block's cells.
  logic [VALUE_BITS-1:0] shadow_value [DEPTH];
  logic [PRIO_W-1:0]     shadow_prio  [DEPTH];
  int                    shadow_count = 0;

  pq_result_t pending_results [$];
  int         mismatches = 0;
  int         cycles = 0;
  bit         quiet = 1'b0;   // no gaps and no stalls on either side
  int         stall_left = 0;

  // Applies one transaction to the shadow queue and returns the result it must produce.
  function automatic pq_result_t queue_step(opcode_t op, logic [VALUE_BITS-1:0] v,
                                            logic [PRIO_W-1:0] p);
    pq_result_t r;
    int         pos;
    r = '{ST_DONE, '0, '0, '0};
    if (op == OP_INSERT) begin
      if (shadow_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of equal or lower priority value
        pos = shadow_count;
        for (int k = 0; k < shadow_count; k++) begin
          if (shadow_prio[k] > p) begin
            pos = k;
            break;
          end
        end
        for (int k = shadow_count; k > pos; k--) begin
          shadow_value[k] = shadow_value[k-1];
          shadow_prio[k]  = shadow_prio[k-1];
        end
        shadow_value[pos] = v;
        shadow_prio[pos]  = p;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.value = shadow_value[0];
      r.prio  = shadow_prio[0];
      for (int k = 0; k + 1 < shadow_count; k++) begin
        shadow_value[k] = shadow_value[k+1];
        shadow_prio[k]  = shadow_prio[k+1];
      end
      shadow_count--;
    end
    r.count = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  // Idle length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly small priorities so ties and FIFO order among equals are common.
  function automatic logic [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return PRIO_W'($urandom_range(0, 3));
    if (r < 70) return PRIO_W'($urandom_range(0, 15));
    if (r < 90) return PRIO_W'($urandom);
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  // Presents one transaction after a random gap and returns at its acceptance edge.
  task automatic send_txn(opcode_t op, logic [VALUE_BITS-1:0] v, logic [PRIO_W-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    item_value    <= v;
    item_priority <= p;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds off the sender until every pending result is out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Output side: check the accepted result, then pick the next stall value.
  always @(posedge clk) begin
    pq_result_t got;
    pq_result_t want;
    int         n;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      got = '{status_t'(status), head_value, head_priority, fill_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("unexpected result: status=%0d value=%h prio=%h count=%0d",
                   got.status, got.value, got.prio, got.count);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("mismatch: exp status=%0d value=%h prio=%h count=%0d | ",
                     want.status, want.value, want.prio, want.count,
                     "got status=%0d value=%h prio=%h count=%0d",
                     got.status, got.value, got.prio, got.count);
        end
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      n = pick_gap();
      out_stall <= (n > 0);
      stall_left = (n > 0) ? n - 1 : 0;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    pq_result_t res;
    opcode_t    op;
    int         sent;
    int         phase;
    int         phase_len;
    int         insert_pct;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: typed-in results where they are obvious, predictor otherwise.
    for (int i = 0; i < DIR_ROWS_N; i++) begin
      send_txn(DIR_ROWS[i].op, DIR_ROWS[i].value, DIR_ROWS[i].prio);
      res = queue_step(DIR_ROWS[i].op, DIR_ROWS[i].value, DIR_ROWS[i].prio);
      if (DIR_ROWS[i].chk) res = DIR_ROWS[i].res;
      pending_results.push_back(res);
    end
    drain();

    // Random part in phases with different insert/remove mix, so the queue
    // swings between empty and full; every phase ends with a full drain.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_TXNS) begin
      case (phase % 5)
        0: insert_pct = 90;
        1: insert_pct = 50;
        2: insert_pct = 10;
        3: insert_pct = 70;
        default: insert_pct = 30;
      endcase
      quiet     = (phase % 4 == 1);
      phase_len = $urandom_range(60, 140);
      for (int i = 0; i < phase_len && sent < RANDOM_TXNS; i++) begin
        logic [VALUE_BITS-1:0] v;
        logic [PRIO_W-1:0]     p;
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        v  = $urandom;
        p  = pick_prio();
        send_txn(op, v, p);
        pending_results.push_back(queue_step(op, v, p));
        sent++;
      end
      drain();
      phase++;
    end

    quiet = 1'b0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
